// File: src/keyed_window_majority_vote_assert.svh
// assertion macros for the keyed window majority vote block
`ifndef KEYED_WINDOW_MAJORITY_VOTE_ASSERT_SVH
`define KEYED_WINDOW_MAJORITY_VOTE_ASSERT_SVH
// implication checked every clock, quiet in reset
`define KWMV_ASSERT_IMP(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication
`define KWMV_ASSERT_NXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// File: src/kwmv_pkg.sv
// shared constants and types for the keyed window majority vote block
`timescale 1ns / 1ps
package kwmv_pkg;
  localparam int Window   = 21;
  localparam int Slots    = 256;
  localparam int IdBits   = 16;
  localparam int SlotBits = 8;
  localparam int PosBits  = 5;
  localparam int AddrBits = $clog2(Slots * Window);
  localparam int ConfCap  = 62259;
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_GUESS  = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_META  = 9'b000000010,
    ST_REC   = 9'b000000100,
    ST_RD    = 9'b000001000,
    ST_CMP   = 9'b000010000,
    ST_NEXT  = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_OUT   = 9'b010000000,
    ST_TALLY = 9'b100000000
  } state_t;
endpackage

// File: src/kwmv_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
module kwmv_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/keyed_window_majority_vote.sv
// Keyed window majority vote: one ring of the last 21 ids per key slot, held in
// a 5376-entry id memory plus a 256-entry start/fill memory. A record beat steps
// through accept, metadata read and ring write. A guess beat on a slot holding
// n ids accepts and reads the metadata, then for each of the n candidate positions
// re-reads the ring from the oldest entry to count that id at one memory read per
// cycle, then runs a restoring divide and loads the result; an empty slot goes
// from the metadata read straight to loading the result. The result sits in the
// output registers until it is taken; records go on meanwhile, and a following
// guess waits in its result stage for as long as the earlier result waits. The
// metadata memory is cleared after reset, slot by slot, and no beat is accepted
// while it clears.
`timescale 1ns / 1ps
module keyed_window_majority_vote (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  key_slot,
  input  logic [15:0] member_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [15:0] guess_id,
  output logic [4:0]  vote_count,
  output logic [4:0]  window_fill,
  output logic [15:0] confidence
);
  `include "keyed_window_majority_vote_assert.svh"
  localparam int AW = kwmv_pkg::AddrBits;
  localparam int PW = kwmv_pkg::PosBits;

  kwmv_pkg::state_t state;
  logic          clearing;
  logic [7:0]    clr_idx;
  logic          op_mode;
  logic [7:0]    op_slot;
  logic [15:0]   op_id;
  logic [PW-1:0] start, fill;
  logic [PW-1:0] cand, scan;      // candidate position, scan position
  logic [15:0]   cand_id;
  logic [PW-1:0] cnt, best_cnt;
  logic [15:0]   best_id;
  logic [16:0]   rem;
  logic [16:0]   quo;
  logic [4:0]    dstep;

  // memory ports
  logic          id_we, meta_we;
  logic [AW-1:0] id_waddr, id_raddr;
  logic [15:0]   id_wdata, id_rdata;
  logic [7:0]    meta_waddr;
  logic [9:0]    meta_wdata, meta_rdata;
  logic [AW-1:0] slot_base;
  logic [PW:0]   pos_sum;
  logic [PW-1:0] pos_wrap;
  logic [PW-1:0] rec_start, rec_fill;

  kwmv_ram #(.Width(16), .Depth(kwmv_pkg::Slots * kwmv_pkg::Window)) u_ids (
    .clk, .we(id_we), .waddr(id_waddr), .wdata(id_wdata),
    .raddr(id_raddr), .rdata(id_rdata));
  kwmv_ram #(.Width(10), .Depth(kwmv_pkg::Slots)) u_meta (
    .clk, .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(op_slot), .rdata(meta_rdata));

  assign in_ready = (state == kwmv_pkg::ST_IDLE) && !clearing;
  assign slot_base = AW'(op_slot) * AW'(kwmv_pkg::Window);

  // record: new start and fill
  always_comb begin
    rec_start = meta_rdata[9:5];
    rec_fill  = meta_rdata[4:0];
    if (rec_fill == PW'(kwmv_pkg::Window)) begin
      rec_start = (rec_start == PW'(kwmv_pkg::Window - 1)) ? '0 : rec_start + 1'b1;
      rec_fill  = rec_fill - 1'b1;
    end
  end

  // ring position to address, start + offset mod window
  always_comb begin
    logic [PW-1:0] off;
    off = (state == kwmv_pkg::ST_META) ? rec_fill : scan;
    if (state == kwmv_pkg::ST_META) pos_sum = {1'b0, rec_start} + {1'b0, off};
    else pos_sum = {1'b0, start} + {1'b0, off};
    pos_wrap = (pos_sum >= (PW+1)'(kwmv_pkg::Window))
               ? PW'(pos_sum - (PW+1)'(kwmv_pkg::Window)) : pos_sum[PW-1:0];
  end

  always_comb begin
    id_we      = (state == kwmv_pkg::ST_META) && (op_mode == kwmv_pkg::MODE_RECORD);
    id_waddr   = slot_base + AW'(pos_wrap);
    id_wdata   = op_id;
    id_raddr   = slot_base + AW'(pos_wrap);
    meta_we    = clearing || id_we;
    meta_waddr = clearing ? clr_idx : op_slot;
    meta_wdata = clearing ? '0 : {rec_start, rec_fill + 1'b1};
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kwmv_pkg::ST_IDLE;
      clearing  <= 1'b1;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == 8'(kwmv_pkg::Slots - 1)) clearing <= 1'b0;
      end
      if (out_valid && out_ready && state != kwmv_pkg::ST_OUT) out_valid <= 1'b0;
      unique case (state)
        kwmv_pkg::ST_IDLE: begin
          if (in_valid && in_ready) begin
            op_mode <= mode;
            op_slot <= key_slot;
            op_id   <= member_id;
            state   <= kwmv_pkg::ST_REC;
          end
        end
        // meta read under way
        kwmv_pkg::ST_REC: state <= kwmv_pkg::ST_META;
        kwmv_pkg::ST_META: begin
          start    <= meta_rdata[9:5];
          fill     <= meta_rdata[4:0];
          cand     <= '0;
          scan     <= '0;
          best_cnt <= '0;
          best_id  <= '0;
          if (op_mode == kwmv_pkg::MODE_RECORD) state <= kwmv_pkg::ST_IDLE;
          else if (meta_rdata[4:0] == '0) state <= kwmv_pkg::ST_OUT;
          else state <= kwmv_pkg::ST_RD;
        end
        // scan == cand: read candidate id
        kwmv_pkg::ST_RD: begin
          scan  <= cand;
          state <= kwmv_pkg::ST_CMP;
        end
        kwmv_pkg::ST_CMP: begin
          cand_id <= id_rdata;
          cnt     <= '0;
          scan    <= '0;
          state   <= kwmv_pkg::ST_TALLY;
        end
        // count cand_id over the ring, one read per cycle
        kwmv_pkg::ST_TALLY: begin
          if (scan != '0 && id_rdata == cand_id) cnt <= cnt + 1'b1;
          scan <= scan + 1'b1;
          if (scan == fill) state <= kwmv_pkg::ST_NEXT;
        end
        // stale read at scan 0 is skipped above; fold last compare in count
        kwmv_pkg::ST_NEXT: begin
          if (cnt > best_cnt) begin
            best_cnt <= cnt;
            best_id  <= cand_id;
          end
          if (cand + 1'b1 == fill) begin
            rem   <= '0;
            quo   <= '0;
            dstep <= '0;
            state <= kwmv_pkg::ST_DIV;
          end else begin
            cand  <= cand + 1'b1;
            scan  <= cand + 1'b1;
            state <= kwmv_pkg::ST_RD;
          end
        end
        // restoring divide of best_cnt<<16 by fill
        kwmv_pkg::ST_DIV: begin
          logic [17:0] r2;
          logic [21:0] num;
          num = {best_cnt, 16'b0} + 22'd0;
          r2  = {rem, num[5'd21 - dstep]};
          if (r2 >= 18'(fill)) begin
            rem <= 17'(r2 - 18'(fill));
            quo <= {quo[15:0], 1'b1};
          end else begin
            rem <= r2[16:0];
            quo <= {quo[15:0], 1'b0};
          end
          dstep <= dstep + 1'b1;
          if (dstep == 5'd21) state <= kwmv_pkg::ST_OUT;
        end
        // load the result once the output registers are free
        kwmv_pkg::ST_OUT: begin
          if (!out_valid || out_ready) begin
            found       <= (fill != '0);
            guess_id    <= best_id;
            vote_count  <= best_cnt;
            window_fill <= fill;
            if (fill == '0) confidence <= '0;
            else confidence <= (quo > 17'(kwmv_pkg::ConfCap))
                               ? 16'(kwmv_pkg::ConfCap) : quo[15:0];
            out_valid <= 1'b1;
            state     <= kwmv_pkg::ST_IDLE;
          end
        end
        default: state <= kwmv_pkg::ST_IDLE;
      endcase
    end
  end

  `KWMV_ASSERT_IMP(a_no_accept_clear, clearing, !in_ready, "beat accepted during clear")
  `KWMV_ASSERT_IMP(a_fill_range, out_valid, window_fill <= 5'd21, "fill out of range")
  `KWMV_ASSERT_IMP(a_count_le_fill, out_valid, vote_count <= window_fill, "count above fill")
  `KWMV_ASSERT_NXT(a_out_idle, state == kwmv_pkg::ST_OUT && (!out_valid || out_ready),
    state == kwmv_pkg::ST_IDLE, "result stage did not return")
  `KWMV_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(guess_id) && $stable(confidence), "waiting result beat changed")
endmodule

// File: verif/keyed_window_majority_vote_tb.sv
// testbench for the keyed window majority vote block: table and random beats
`timescale 1ns / 1ps
module keyed_window_majority_vote_tb;

  typedef struct packed {
    logic        found;
    logic [15:0] guess_id;
    logic [4:0]  vote_count;
    logic [4:0]  window_fill;
    logic [15:0] confidence;
  } vote_t;

  typedef struct packed {
    logic        mode;
    logic [7:0]  key_slot;
    logic [15:0] member_id;
    logic        typed;
    vote_t       want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic [7:0]  key_slot;
  logic [15:0] member_id;
  logic        out_valid;
  logic        out_ready;
  logic        found;
  logic [15:0] guess_id;
  logic [4:0]  vote_count;
  logic [4:0]  window_fill;
  logic [15:0] confidence;

  keyed_window_majority_vote u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .key_slot(key_slot), .member_id(member_id),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .guess_id(guess_id), .vote_count(vote_count),
    .window_fill(window_fill), .confidence(confidence)
  );

  // shadow copy of the per-slot rings
  logic [15:0] ring_ids [kwmv_pkg::Slots][kwmv_pkg::Window];
  int          ring_head [kwmv_pkg::Slots];
  int          ring_len [kwmv_pkg::Slots];

  vote_t pending_votes[$];
  int    mismatches;
  int    cycles;
  bit    hold_req = 1'b0;
  bit    stim_done;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // append an id, dropping the oldest when the ring is full
  function automatic void log_member(input logic [7:0] s, input logic [15:0] id);
    if (ring_len[s] == kwmv_pkg::Window) begin
      ring_head[s] = (ring_head[s] + 1) % kwmv_pkg::Window;
      ring_len[s]--;
    end
    ring_ids[s][(ring_head[s] + ring_len[s]) % kwmv_pkg::Window] = id;
    ring_len[s]++;
  endfunction

  // majority id, earliest first occurrence wins ties
  function automatic vote_t tally_vote(input logic [7:0] s);
    vote_t  v;
    logic [15:0] cand;
    int     n;
    int     best;
    longint q;
    v = '0;
    best = 0;
    if (ring_len[s] == 0) return v;
    for (int i = 0; i < ring_len[s]; i++) begin
      cand = ring_ids[s][(ring_head[s] + i) % kwmv_pkg::Window];
      n = 0;
      for (int j = 0; j < ring_len[s]; j++)
        if (ring_ids[s][(ring_head[s] + j) % kwmv_pkg::Window] == cand) n++;
      if (n > best) begin
        best = n;
        v.guess_id = cand;
      end
    end
    q = (longint'(best) << 16) / ring_len[s];
    if (q > kwmv_pkg::ConfCap) q = kwmv_pkg::ConfCap;
    v.found = 1'b1;
    v.vote_count = best[4:0];
    v.window_fill = ring_len[s][4:0];
    v.confidence = q[15:0];
    return v;
  endfunction

  // offer one beat, holding it until accepted
  task automatic send_beat(input logic m, input logic [7:0] s, input logic [15:0] id,
                           input logic typed, input vote_t want);
    vote_t v;
    mode <= m;
    key_slot <= s;
    member_id <= id;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (m == kwmv_pkg::MODE_RECORD) log_member(s, id);
    else begin
      v = tally_vote(s);
      pending_votes.push_back(typed ? want : v);
    end
    @(negedge clk);
  endtask

  // gap after a beat, bursts with random idle stretches
  int burst_left;
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 8)) @(negedge clk);
    burst_left = $urandom_range(0, 12);
  endtask

  // random beat, mostly on a few hot slots with a small id pool
  task automatic random_beat();
    logic [7:0]  s;
    logic [15:0] id;
    logic        m;
    s = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 5)) : 8'($urandom);
    id = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 4)) : 16'($urandom);
    m = ($urandom_range(0, 2) == 0) ? kwmv_pkg::MODE_GUESS : kwmv_pkg::MODE_RECORD;
    send_beat(m, s, id, 1'b0, '0);
  endtask

  row_t rows[$];
  vote_t zero_vote;

  initial begin
    for (int i = 0; i < kwmv_pkg::Slots; i++) begin
      ring_head[i] = 0;
      ring_len[i] = 0;
    end
    rst = 1'b1;
    in_valid = 1'b0;
    mode = kwmv_pkg::MODE_RECORD;
    key_slot = '0;
    member_id = '0;
    mismatches = 0;
    stim_done = 1'b0;
    burst_left = 0;
    zero_vote = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty slots at both extremes
    rows.push_back({kwmv_pkg::MODE_GUESS, 8'd0, 16'h0000, 1'b1, zero_vote});
    rows.push_back({kwmv_pkg::MODE_GUESS, 8'd255, 16'hFFFF, 1'b1, zero_vote});
    // single id: full confidence saturates
    rows.push_back({kwmv_pkg::MODE_RECORD, 8'd255, 16'hFFFF, 1'b0, zero_vote});
    rows.push_back({kwmv_pkg::MODE_GUESS, 8'd255, 16'h0000, 1'b1,
                    vote_t'({1'b1, 16'hFFFF, 5'd1, 5'd1, 16'(kwmv_pkg::ConfCap)})});
    // tie: oldest first occurrence wins
    rows.push_back({kwmv_pkg::MODE_RECORD, 8'd7, 16'h00AA, 1'b0, zero_vote});
    rows.push_back({kwmv_pkg::MODE_RECORD, 8'd7, 16'h5555, 1'b0, zero_vote});
    rows.push_back({kwmv_pkg::MODE_RECORD, 8'd7, 16'h5555, 1'b0, zero_vote});
    rows.push_back({kwmv_pkg::MODE_RECORD, 8'd7, 16'h00AA, 1'b0, zero_vote});
    rows.push_back({kwmv_pkg::MODE_GUESS, 8'd7, 16'h1234, 1'b1,
                    vote_t'({1'b1, 16'h00AA, 5'd2, 5'd4, 16'd32768})});
    rows.push_back({kwmv_pkg::MODE_RECORD, 8'd0, 16'h0000, 1'b0, zero_vote});
    rows.push_back({kwmv_pkg::MODE_GUESS, 8'd0, 16'h0000, 1'b0, zero_vote});
    foreach (rows[i])
      send_beat(rows[i].mode, rows[i].key_slot, rows[i].member_id, rows[i].typed,
                rows[i].want);

    // wrap slot 3 past a full window, guessing along the way
    for (int i = 0; i < 25; i++) begin
      send_beat(kwmv_pkg::MODE_RECORD, 8'd3, 16'(i % 3 == 0 ? 16'h8001 : i), 1'b0, '0);
      if (i % 6 == 5) send_beat(kwmv_pkg::MODE_GUESS, 8'd3, '0, 1'b0, '0);
    end
    send_beat(kwmv_pkg::MODE_GUESS, 8'd3, '0, 1'b0, '0);

    // long receiver hold-off while beats keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) random_beat();

    for (int i = 0; i < 580; i++) begin
      random_beat();
      pace();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stall pattern plus one long hold-off
  int stall_run;
  int hold_left;
  bit hold_done;
  initial begin
    out_ready = 1'b0;
    stall_run = 0;
    hold_left = 0;
    hold_done = 1'b0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 3000;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_run > 0) begin
        out_ready <= 1'b0;
        stall_run--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) stall_run = $urandom_range(1, 15);
      end
    end
  end

  // compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin
    vote_t got;
    vote_t want;
    if (!rst && out_valid && out_ready) begin
      got = {found, guess_id, vote_count, window_fill, confidence};
      if (pending_votes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_votes.pop_front();
        if (got.found !== want.found || got.guess_id !== want.guess_id ||
            got.vote_count !== want.vote_count || got.window_fill !== want.window_fill ||
            got.confidence !== want.confidence) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: want f=%0d id=%h n=%0d fill=%0d conf=%0d",
                     want.found, want.guess_id, want.vote_count, want.window_fill,
                     want.confidence);
            $display("           got f=%0d id=%h n=%0d fill=%0d conf=%0d",
                     got.found, got.guess_id, got.vote_count, got.window_fill,
                     got.confidence);
          end
        end
      end
    end
  end

  // end of run and timeout
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("Some tests failed");
        $finish;
      end
      if (stim_done && pending_votes.size() == 0) begin
        repeat (600) @(posedge clk);
        if (mismatches == 0 && pending_votes.size() == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
      end
    end
  end
endmodule

// File: sim.f
+incdir+src
src/kwmv_pkg.sv
src/kwmv_ram.sv
src/keyed_window_majority_vote.sv
verif/keyed_window_majority_vote_tb.sv
